/* rtl/core/ple_pkg.sv */
// shared types and constants for the positional list engine
package ple_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int POS_W    = 7;
	localparam int VAL_W    = 32;

	localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_DELETE   = 3'd1,
		OP_RETRIEVE = 3'd2,
		OP_REPLACE  = 3'd3,
		OP_CLEAR    = 3'd4
	} req_op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_NOPOS = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_INS_CHK,
		S_INS_RD,
		S_INS_WR,
		S_PUT,
		S_FETCH_RD,
		S_FETCH_WAIT,
		S_DEL_CHK,
		S_DEL_RD,
		S_DEL_WR,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic [1:0]       status;
		logic [CNT_W-1:0] entry_count;
		logic             is_empty;
	} res_t;

endpackage

/* rtl/core/ple_ram.sv */
// generic single write, single read ram with registered read data
module ple_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/ple_seq.sv */
// request sequencer: range checks, entry shifting and result assembly
module ple_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ple_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output ple_pkg::res_t res
);

	import ple_pkg::*;

	seq_state_t       state_q, state_d;
	req_op_t          op_q, op_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [VAL_W-1:0] val_q, val_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [VAL_W-1:0] rd_q, rd_d;
	status_t          st_q, st_d;

	// shared index unit: one adder stepping down for insert, up otherwise
	logic             step_dec;
	logic [CNT_W-1:0] step;

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [VAL_W-1:0] ram_wdata, ram_rdata;

	assign step_dec = (op_q == OP_INSERT);
	assign step     = step_dec ? (idx_q - CNT_W'(1)) : (idx_q + CNT_W'(1));

	ple_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(VAL_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		pos_q <= pos_d;
		val_q <= val_d;
		idx_q <= idx_d;
		rd_q  <= rd_d;
		st_q  <= st_d;
	end

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		pos_d     = pos_q;
		val_d     = val_q;
		idx_d     = idx_q;
		count_d   = count_q;
		rd_d      = rd_q;
		st_d      = st_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = step[IDX_W-1:0];
		req_ready = 1'b0;
		res_valid = 1'b0;

		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					op_d    = req_op_t'(req.req_type);
					pos_d   = req.position;
					val_d   = req.value;
					rd_d    = '0;
					st_d    = ST_DONE;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				case (op_q)
					OP_INSERT: begin
						if (pos_q > count_q) begin
							st_d    = ST_NOPOS;
							state_d = S_DONE;
						end else if (count_q >= CAP_COUNT) begin
							st_d    = ST_FULL;
							state_d = S_DONE;
						end else begin
							idx_d   = count_q;
							state_d = S_INS_CHK;
						end
					end
					OP_DELETE, OP_RETRIEVE: begin
						if (pos_q >= count_q) begin
							st_d    = ST_NOPOS;
							state_d = S_DONE;
						end else begin
							state_d = S_FETCH_RD;
						end
					end
					OP_REPLACE: begin
						if (pos_q >= count_q) begin
							st_d    = ST_NOPOS;
							state_d = S_DONE;
						end else begin
							state_d = S_PUT;
						end
					end
					OP_CLEAR: begin
						count_d = '0;
						state_d = S_DONE;
					end
					default: begin
						st_d    = ST_NOPOS;
						state_d = S_DONE;
					end
				endcase
			end
			// walk down from the old top, moving each entry one slot up
			S_INS_CHK: begin
				if (idx_q > pos_q) begin
					state_d = S_INS_RD;
				end else begin
					state_d = S_PUT;
				end
			end
			S_INS_RD: begin
				ram_re  = 1'b1;
				state_d = S_INS_WR;
			end
			S_INS_WR: begin
				ram_we  = 1'b1;
				idx_d   = step;
				state_d = S_INS_CHK;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[IDX_W-1:0];
				ram_wdata = val_q;
				if (op_q == OP_INSERT) begin
					count_d = count_q + CNT_W'(1);
				end
				state_d = S_DONE;
			end
			S_FETCH_RD: begin
				ram_re    = 1'b1;
				ram_raddr = pos_q[IDX_W-1:0];
				state_d   = S_FETCH_WAIT;
			end
			S_FETCH_WAIT: begin
				rd_d = ram_rdata;
				if (op_q == OP_DELETE) begin
					idx_d   = pos_q;
					state_d = S_DEL_CHK;
				end else begin
					state_d = S_DONE;
				end
			end
			// walk up from the hole, pulling each entry one slot down
			S_DEL_CHK: begin
				if (step < count_q) begin
					state_d = S_DEL_RD;
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = S_DONE;
				end
			end
			S_DEL_RD: begin
				ram_re  = 1'b1;
				state_d = S_DEL_WR;
			end
			S_DEL_WR: begin
				ram_we  = 1'b1;
				idx_d   = step;
				state_d = S_DEL_CHK;
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res.read_value  = rd_q;
	assign res.status      = st_q;
	assign res.entry_count = count_q;
	assign res.is_empty    = (count_q == '0);

endmodule

/* rtl/core/positional_list_engine_unit.sv */
// top level of the positional list engine with its result register
//
// request channel: req_valid / req_ready carry one word of req_type,
// position and value. result channel: res_valid / res_ready carry one
// word of read_value, status, entry_count and is_empty per request.
// requests are handled one at a time by a sequencer around a single
// index adder and a one-read, one-write entry ram with registered read.
// insert moves every entry at or above the position one slot up, delete
// every entry above the deleted one a slot down; each entry move is a
// ram read, a ram write and an index check. a new request is taken only
// after the sequencer has passed the result of the last one on.
// a finished word waits in the output register; the next request is
// taken while it waits, and the sequencer only holds if the register is
// still full when its own result is ready.
// reset clears the entry count, sequencer state and output valid flag;
// entries are not cleared and need no sweep, as only written slots are read.
module positional_list_engine_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [2:0]                   req_type,
	input  logic [ple_pkg::POS_W-1:0]    position,
	input  logic signed [ple_pkg::VAL_W-1:0] value,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic signed [ple_pkg::VAL_W-1:0] read_value,
	output logic [1:0]                   status,
	output logic [ple_pkg::CNT_W-1:0]    entry_count,
	output logic                         is_empty
);

	import ple_pkg::*;

	req_t req;
	res_t seq_res;
	logic seq_valid;
	logic seq_ready;

	// output register: one word of result held for the receiver
	logic out_valid_q;
	res_t out_q;

	assign req.req_type = req_type;
	assign req.position = position;
	assign req.value    = value;

	ple_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.res_valid(seq_valid),
		.res_ready(seq_ready),
		.res      (seq_res)
	);

	// the slot frees the same cycle the receiver takes the held word
	assign seq_ready = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_ready) begin
			out_valid_q <= seq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_ready && seq_valid) begin
			out_q <= seq_res;
		end
	end

	assign res_valid   = out_valid_q;
	assign read_value  = out_q.read_value;
	assign status      = out_q.status;
	assign entry_count = out_q.entry_count;
	assign is_empty    = out_q.is_empty;

endmodule
